// File: rtl/vwfp_pkg.sv
// Shared constants and types for the variable width field packer.
`default_nettype none

package vwfp_pkg;

  localparam int VALUE_BITS          = 16;
  localparam int WIDTH_BITS          = 5;
  localparam int BYTE_BITS           = 8;
  localparam int PEND_BITS           = 7;
  localparam int CNT_BITS            = 3;
  localparam int MAX_RESULTS         = 3;
  localparam int RES_CNT_BITS        = 2;
  localparam int WINDOW_BITS         = MAX_RESULTS * BYTE_BITS;
  localparam int MAX_FIELD_WIDTH_DEF = 16;

  typedef struct packed {
    logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] bytes;
    logic [RES_CNT_BITS-1:0]               count;
    logic                                  last_on_final;
  } vwfp_result_t;

endpackage

`default_nettype wire

// File: rtl/variable_width_field_packer_unit.sv
// Top level of the variable width field packer: input register, packer, result buffer.
//
//  channel | handshake             | word
//  --------+-----------------------+----------------------------------------------
//  in      | in_valid / in_stall   | field_value, field_width, is_signed, end_of_packet
//  out     | out_valid / out_stall | out_byte, last_byte
//
// A field is registered, then packed in one pass into 0..3 bytes held in the result buffer.
// One field a cycle while each gives at most one byte and out is not stalled; otherwise the
// output port, one byte a cycle unless stalled, sets the rate. The first byte is valid once
// the input register has passed the field through the packer into the result buffer.
// Reset empties the pending bits and both stages. A stall on out holds the buffer and,
// once the input register is full, raises in_stall.
`default_nettype none

module variable_width_field_packer_unit
  import vwfp_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [VALUE_BITS-1:0] field_value,
  input  wire logic [WIDTH_BITS-1:0] field_width,
  input  wire logic                  is_signed,
  input  wire logic                  end_of_packet,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [BYTE_BITS-1:0]  out_byte,
  output logic                       last_byte
);

  logic                  s1_valid;
  logic [VALUE_BITS-1:0] s1_value;
  logic [WIDTH_BITS-1:0] s1_width;
  logic                  s1_signed;
  logic                  s1_eop;

  logic [PEND_BITS-1:0]  pending_bits;
  logic [CNT_BITS-1:0]   pending_count;
  logic [PEND_BITS-1:0]  pending_bits_next;
  logic [CNT_BITS-1:0]   pending_count_next;

  logic [VALUE_BITS-1:0] field_bits;
  logic [WIDTH_BITS-1:0] eff_width;
  vwfp_result_t          res;
  logic                  free;
  logic                  advance;
  logic                  accept;

  assign advance  = s1_valid && free;
  assign in_stall = s1_valid && !free;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_value  <= field_value;
      s1_width  <= field_width;
      s1_signed <= is_signed;
      s1_eop    <= end_of_packet;
    end
  end

  vwfp_field_bits #(
    .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)
  ) u_field_bits (
    .field_value(s1_value),
    .field_width(s1_width),
    .is_signed  (s1_signed),
    .field_bits (field_bits),
    .eff_width  (eff_width)
  );

  vwfp_byte_pack u_byte_pack (
    .pending_bits      (pending_bits),
    .pending_count     (pending_count),
    .field_bits        (field_bits),
    .eff_width         (eff_width),
    .end_of_packet     (s1_eop),
    .res               (res),
    .pending_bits_next (pending_bits_next),
    .pending_count_next(pending_count_next)
  );

  vwfp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (advance),
    .res      (res),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_byte (out_byte),
    .last_byte(last_byte),
    .free     (free)
  );

  a_eop_clears: assert property (@(posedge clk) disable iff (rst)
    advance && s1_eop |=> pending_count == '0 && pending_bits == '0)
    else $error("pending bits left after end of packet");

  a_pending_clean: assert property (@(posedge clk) disable iff (rst)
    (pending_bits >> pending_count) == '0)
    else $error("stale bits above pending count");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with nothing held");

endmodule

`default_nettype wire

// File: rtl/vwfp_field_bits.sv
// Field formatter: clamps the width and lays the field out in stream order, first bit on top.
`default_nettype none

module vwfp_field_bits
  import vwfp_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
  input  wire logic [VALUE_BITS-1:0] field_value,
  input  wire logic [WIDTH_BITS-1:0] field_width,
  input  wire logic                  is_signed,
  output logic      [VALUE_BITS-1:0] field_bits,
  output logic      [WIDTH_BITS-1:0] eff_width
);

  localparam int LIM = (MAX_FIELD_WIDTH < VALUE_BITS) ? MAX_FIELD_WIDTH : VALUE_BITS;
  localparam logic [WIDTH_BITS-1:0] LIM_W = WIDTH_BITS'(LIM);

  logic                  sign;
  logic [VALUE_BITS-1:0] mag;
  logic [WIDTH_BITS-1:0] wm1;

  always_comb begin
    eff_width = (field_width > LIM_W) ? LIM_W : field_width;
    wm1       = eff_width - WIDTH_BITS'(1);
    sign      = field_value[VALUE_BITS-1];
    mag       = sign ? (VALUE_BITS'(0) - field_value) : field_value;
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (WIDTH_BITS'(i) >= eff_width) begin
        field_bits[VALUE_BITS-1-i] = 1'b0;
      end else if (is_signed) begin
        field_bits[VALUE_BITS-1-i] = (WIDTH_BITS'(i) == wm1) ? sign : mag[i];
      end else begin
        field_bits[VALUE_BITS-1-i] = field_value[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/vwfp_byte_pack.sv
// Byte packer: merges pending bits with a field and splits the window into bytes.
`default_nettype none

module vwfp_byte_pack
  import vwfp_pkg::*;
(
  input  wire logic [PEND_BITS-1:0]  pending_bits,
  input  wire logic [CNT_BITS-1:0]   pending_count,
  input  wire logic [VALUE_BITS-1:0] field_bits,
  input  wire logic [WIDTH_BITS-1:0] eff_width,
  input  wire logic                  end_of_packet,
  output vwfp_result_t               res,
  output logic      [PEND_BITS-1:0]  pending_bits_next,
  output logic      [CNT_BITS-1:0]   pending_count_next
);

  logic [BYTE_BITS-1:0]    p8;
  logic [WINDOW_BITS-1:0]  window;
  logic [WIDTH_BITS-1:0]   total;
  logic [RES_CNT_BITS-1:0] full;
  logic [CNT_BITS-1:0]     rem;
  logic [BYTE_BITS-1:0]    part;
  logic [BYTE_BITS:0]      part_sh;

  always_comb begin
    p8 = BYTE_BITS'({1'b0, pending_bits} << (4'd8 - {1'b0, pending_count}));
    window = {p8, {VALUE_BITS{1'b0}}}
           | ({field_bits, {BYTE_BITS{1'b0}}} >> pending_count);
    total = WIDTH_BITS'(pending_count) + eff_width;
    full  = total[WIDTH_BITS-1:CNT_BITS];
    rem   = total[CNT_BITS-1:0];

    for (int k = 0; k < MAX_RESULTS; k++) begin
      res.bytes[k] = window[WINDOW_BITS-1-k*BYTE_BITS -: BYTE_BITS];
    end
    res.count         = full + RES_CNT_BITS'(end_of_packet && (rem != '0));
    res.last_on_final = end_of_packet;

    case (full)
      2'd0:    part = window[23:16];
      2'd1:    part = window[15:8];
      default: part = window[7:0];
    endcase
    part_sh = {1'b0, part} >> (4'd8 - {1'b0, rem});

    if (end_of_packet) begin
      pending_bits_next  = '0;
      pending_count_next = '0;
    end else begin
      pending_bits_next  = part_sh[PEND_BITS-1:0];
      pending_count_next = rem;
    end
  end

endmodule

`default_nettype wire

// File: rtl/vwfp_out_buf.sv
// Result buffer: holds up to three bytes of a field, hands out one a cycle unless stalled.
`default_nettype none

module vwfp_out_buf
  import vwfp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 load,
  input  wire vwfp_result_t         res,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic      [BYTE_BITS-1:0] out_byte,
  output logic                      last_byte,
  output logic                      free
);

  logic [MAX_RESULTS-1:0][BYTE_BITS-1:0] bytes;
  logic [MAX_RESULTS-1:0]                lasts;
  logic [RES_CNT_BITS-1:0]               count;
  logic                                  take;

  assign out_valid = (count != '0);
  assign out_byte  = bytes[0];
  assign last_byte = lasts[0];
  assign take      = out_valid && !out_stall;
  assign free      = (count == '0) || ((count == RES_CNT_BITS'(1)) && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= res.count;
    end else if (take) begin
      count <= count - RES_CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      for (int k = 0; k < MAX_RESULTS; k++) begin
        lasts[k] <= res.last_on_final && (RES_CNT_BITS'(k) == res.count - RES_CNT_BITS'(1));
      end
    end else if (take) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) begin
        bytes[k] <= bytes[k+1];
        lasts[k] <= lasts[k+1];
      end
      bytes[MAX_RESULTS-1] <= '0;
      lasts[MAX_RESULTS-1] <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// File: dv/vwfp_stream_checker.sv
// Watches both channels of the field packer, predicts the byte stream and compares it.
`default_nettype none

module vwfp_stream_checker
  import vwfp_pkg::*;
#(
  parameter int MAX_FIELD_WIDTH = MAX_FIELD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [VALUE_BITS-1:0] field_value,
  input  wire logic [WIDTH_BITS-1:0] field_width,
  input  wire logic                  is_signed,
  input  wire logic                  end_of_packet,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [BYTE_BITS-1:0]  out_byte,
  input  wire logic                  last_byte,
  output int                         fail_count,
  output int                         bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data;
    logic                 last;
  } stream_byte_t;

  stream_byte_t         owed_q[$];
  stream_byte_t         head;
  logic [BYTE_BITS-1:0] acc_bits;
  int                   acc_cnt;

  // Appends one field to the bit stream and queues every byte it completes.
  task automatic pack_field(input logic [VALUE_BITS-1:0] v, input logic [WIDTH_BITS-1:0] w,
                            input logic s, input logic e);
    logic [BYTE_BITS-1:0]  made [MAX_RESULTS];
    logic [VALUE_BITS-1:0] mag;
    logic                  bitv;
    stream_byte_t          entry;
    int                    eff;
    int                    n;
    eff = int'(w);
    if (eff > MAX_FIELD_WIDTH) eff = MAX_FIELD_WIDTH;
    if (eff > VALUE_BITS) eff = VALUE_BITS;
    // magnitude of the most negative value wraps to itself; its low bits are zero
    mag = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
    n = 0;
    for (int i = 0; i < eff; i++) begin
      if (!s) begin
        bitv = v[i];
      end else if (i == eff - 1) begin
        bitv = v[VALUE_BITS-1];
      end else begin
        bitv = mag[i];
      end
      acc_bits = {acc_bits[BYTE_BITS-2:0], bitv};
      acc_cnt++;
      if (acc_cnt == BYTE_BITS) begin
        made[n] = acc_bits;
        n++;
        acc_bits = '0;
        acc_cnt = 0;
      end
    end
    if (e && acc_cnt > 0) begin
      made[n] = acc_bits << (BYTE_BITS - acc_cnt);
      n++;
      acc_bits = '0;
      acc_cnt = 0;
    end
    for (int k = 0; k < n; k++) begin
      entry.data = made[k];
      entry.last = e && (k == n - 1);
      owed_q.push_back(entry);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc_bits = '0;
      acc_cnt = 0;
      owed_q.delete();
      fail_count = 0;
      bytes_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected word %02h last %0b", $realtime, out_byte, last_byte);
        end else begin
          head = owed_q.pop_front();
          if (out_byte !== head.data || last_byte !== head.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: word mismatch, expected %02h last %0b, got %02h last %0b",
                       $realtime, head.data, head.last, out_byte, last_byte);
          end
        end
      end
      if (in_valid && !in_stall)
        pack_field(field_value, field_width, is_signed, end_of_packet);
      bytes_owed = owed_q.size();
    end
  end

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench top for the field packer: clock, reset, field stimulus, output stalls and verdict.
`default_nettype none

module tb_top
  import vwfp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 500;

  typedef enum int {FLOW, CHOPPY, BLOCKED} stall_mode_e;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] field_value;
  logic [WIDTH_BITS-1:0] field_width;
  logic                  is_signed;
  logic                  end_of_packet;
  logic                  out_valid;
  logic                  out_stall;
  logic [BYTE_BITS-1:0]  out_byte;
  logic                  last_byte;
  int                    fail_count;
  int                    bytes_owed;
  int                    quiet_cycles;
  int                    stall_left;
  stall_mode_e           stall_mode;

  variable_width_field_packer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .field_value   (field_value),
    .field_width   (field_width),
    .is_signed     (is_signed),
    .end_of_packet (end_of_packet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_byte     (last_byte)
  );

  vwfp_stream_checker packer_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .field_value   (field_value),
    .field_width   (field_width),
    .is_signed     (is_signed),
    .end_of_packet (end_of_packet),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .last_byte     (last_byte),
    .fail_count    (fail_count),
    .bytes_owed    (bytes_owed)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // receiver: free-flowing, choppy and blocked stretches
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    stall_mode = FLOW;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      stall_left = (stall_mode == BLOCKED) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    stall_left--;
    case (stall_mode)
      FLOW:    out_stall <= 1'b0;
      CHOPPY:  out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("[variable_width_field_packer_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic [WIDTH_BITS-1:0] w,
                           input logic s, input logic e);
    @(negedge clk);
    in_valid      <= 1'b1;
    field_value   <= v;
    field_width   <= w;
    is_signed     <= s;
    end_of_packet <= e;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
  endtask

  initial begin
    int                    sent;
    int                    pkt_len;
    int                    burst_left;
    int                    gap;
    int                    pick;
    logic [VALUE_BITS-1:0] v;
    logic [WIDTH_BITS-1:0] w;
    logic                  s;
    logic                  e;
    bit                    broken;
    bit                    drained_mid;

    rst           = 1'b1;
    in_valid      = 1'b0;
    field_value   = '0;
    field_width   = '0;
    is_signed     = 1'b0;
    end_of_packet = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(16'hFFFF, 5'd16, 1'b0, 1'b0);
    send_word(16'h0000, 5'd16, 1'b0, 1'b0);
    send_word(16'h8000, 5'd16, 1'b1, 1'b0);
    send_word(16'h7FFF, 5'd16, 1'b1, 1'b0);
    send_word(16'hFFFF, 5'd16, 1'b1, 1'b1);  // packet ends on a byte boundary
    send_word(16'h0000, 5'd0,  1'b0, 1'b1);  // empty flush, no word
    send_word(16'h1234, 5'd0,  1'b1, 1'b0);
    send_word(16'h0001, 5'd1,  1'b1, 1'b0);  // sign only
    send_word(16'hFFFF, 5'd1,  1'b1, 1'b0);
    send_word(16'h0001, 5'd1,  1'b0, 1'b0);
    send_word(16'hA5C3, 5'd31, 1'b0, 1'b0);  // clipped width
    send_word(16'h5A3C, 5'd17, 1'b1, 1'b0);
    send_word(16'h0005, 5'd3,  1'b0, 1'b1);  // padded flush
    send_word(16'h00AB, 5'd8,  1'b0, 1'b1);
    send_word(16'h8000, 5'd5,  1'b1, 1'b1);
    send_word(16'h0155, 5'd24, 1'b1, 1'b0);
    send_word(16'h003F, 5'd7,  1'b0, 1'b1);
    send_word(16'hFFFF, 5'd15, 1'b1, 1'b0);
    send_word(16'h8001, 5'd16, 1'b1, 1'b1);
    drain();

    sent = 0;
    burst_left = 0;
    drained_mid = 1'b0;
    while (sent < RANDOM_WORDS) begin
      pkt_len = $urandom_range(1, 8);
      broken = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < pkt_len; k++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 12);
          if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        pick = $urandom_range(0, 9);
        case (pick)
          0:       v = 16'h8000;
          1:       v = 16'hFFFF;
          2:       v = 16'h0000;
          3:       v = 16'h7FFF;
          default: v = VALUE_BITS'($urandom_range(0, 16'hFFFF));
        endcase
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          w = '0;
        end else if (pick == 1) begin
          w = WIDTH_BITS'($urandom_range(17, 31));
        end else begin
          w = WIDTH_BITS'($urandom_range(1, 16));
        end
        s = 1'($urandom_range(0, 1));
        e = broken ? ($urandom_range(0, 3) == 0) : (k == pkt_len - 1);
        send_word(v, w, s, e);
        burst_left--;
        if (w != 0 || e) sent++;
        if (!drained_mid && sent >= RANDOM_WORDS / 2) begin
          drain();
          drained_mid = 1'b1;
        end
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("[variable_width_field_packer_unit] OK");
    end else begin
      $display("[variable_width_field_packer_unit] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: variable_width_field_packer_unit.f
rtl/vwfp_pkg.sv
rtl/vwfp_field_bits.sv
rtl/vwfp_byte_pack.sv
rtl/vwfp_out_buf.sv
rtl/variable_width_field_packer_unit.sv
dv/vwfp_stream_checker.sv
dv/tb_top.sv
